@@ hw/rtl/esba_pkg.sv @@
// ----------------------------------------------------------------------------
// esba_pkg
// Shared types, constants and arithmetic helpers for the elasticity
// stiffness block accumulator.
// ----------------------------------------------------------------------------
package esba_pkg;

    localparam int IN_W           = 32;
    localparam int ACC_W          = 64;
    localparam int SUM_W          = 68;
    localparam int N_ENT          = 9;
    localparam int N_TERMS        = 5;
    localparam int LANE_STG       = N_TERMS + 1;
    localparam int TOP_STG        = LANE_STG + 2;
    localparam int CELLS_PER_NODE = 8;
    localparam int CNT_W          = (CELLS_PER_NODE > 1) ? $clog2(CELLS_PER_NODE) : 1;

    typedef logic signed [IN_W-1:0]  t_in;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [CNT_W-1:0]        t_cnt;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_cnt CNT_LAST = t_cnt'(CELLS_PER_NODE - 1);

    // composed saturating adds: x -> clamp(x + tot, lo, hi), plus prefix sum range
    typedef struct packed {
        t_sum tot;
        t_acc lo;
        t_acc hi;
        t_sum smax;
        t_sum smin;
    } t_comp;

    typedef struct packed {
        t_sum tot;
        t_acc lo;
        t_acc hi;
        t_sum bhi;
        t_sum blo;
    } t_bnd;

    typedef struct packed {
        logic [LANE_STG-1:0] ld;
        logic                acc_en;
        logic                acc_clr;
    } t_lane_ctl;

    localparam t_comp COMP_INIT = '{
        tot:  '0,
        lo:   ACC_MIN,
        hi:   ACC_MAX,
        smax: '0,
        smin: '0
    };

    function automatic t_acc sat_acc(t_sum x);
        t_acc y;
        if (x > t_sum'(ACC_MAX)) begin
            y = ACC_MAX;
        end else if (x < t_sum'(ACC_MIN)) begin
            y = ACC_MIN;
        end else begin
            y = t_acc'(x);
        end
        return y;
    endfunction

    function automatic t_comp comp_step(t_comp c, t_acc t);
        t_comp n;
        n.tot  = c.tot + t_sum'(t);
        n.lo   = sat_acc(t_sum'(c.lo) + t_sum'(t));
        n.hi   = sat_acc(t_sum'(c.hi) + t_sum'(t));
        n.smax = (n.tot > c.smax) ? n.tot : c.smax;
        n.smin = (n.tot < c.smin) ? n.tot : c.smin;
        return n;
    endfunction

    function automatic t_bnd make_bnd(t_comp c);
        t_bnd b;
        b.tot = c.tot;
        b.lo  = c.lo;
        b.hi  = c.hi;
        b.bhi = t_sum'(ACC_MAX) - c.smax;
        b.blo = t_sum'(ACC_MIN) - c.smin;
        return b;
    endfunction

endpackage

@@ hw/rtl/esba_lane.sv @@
// ----------------------------------------------------------------------------
// esba_lane
// One stiffness entry: folds its five terms into a single clamped offset
// over a short pipeline, then applies it to the entry's accumulator.
// ----------------------------------------------------------------------------
module esba_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esba_pkg::t_lane_ctl i_ctl,
    input  esba_pkg::t_acc      i_term [esba_pkg::N_TERMS],
    output esba_pkg::t_acc      o_acc_next,
    output logic                o_sat
);

    esba_pkg::t_comp r_cmp  [esba_pkg::N_TERMS];
    esba_pkg::t_acc  r_term [esba_pkg::N_TERMS-1][esba_pkg::N_TERMS];
    esba_pkg::t_bnd  r_bnd;
    esba_pkg::t_acc  r_acc;
    esba_pkg::t_acc  n_acc;
    esba_pkg::t_sum  w_acc_ext;
    esba_pkg::t_sum  w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_cmp[0]  <= esba_pkg::comp_step(esba_pkg::COMP_INIT, i_term[0]);
            r_term[0] <= i_term;
        end
    end

    for (genvar j = 1; j < esba_pkg::N_TERMS; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_ctl.ld[j]) begin
                r_cmp[j] <= esba_pkg::comp_step(r_cmp[j-1], r_term[j-1][j]);
            end
        end
        if (j < esba_pkg::N_TERMS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.ld[j]) begin
                    r_term[j] <= r_term[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[esba_pkg::N_TERMS]) begin
            r_bnd <= esba_pkg::make_bnd(r_cmp[esba_pkg::N_TERMS-1]);
        end
    end

    always_comb begin
        w_acc_ext = esba_pkg::t_sum'(r_acc);
        w_sum     = w_acc_ext + r_bnd.tot;
        if (w_sum < esba_pkg::t_sum'(r_bnd.lo)) begin
            n_acc = r_bnd.lo;
        end else if (w_sum > esba_pkg::t_sum'(r_bnd.hi)) begin
            n_acc = r_bnd.hi;
        end else begin
            n_acc = esba_pkg::t_acc'(w_sum);
        end
        o_sat = (w_acc_ext > r_bnd.bhi) || (w_acc_ext < r_bnd.blo);
    end

    assign o_acc_next = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_clr ? '0 : n_acc;
        end
    end

endmodule

@@ hw/rtl/elasticity_stiffness_block_accumulator.sv @@
// ----------------------------------------------------------------------------
// elasticity_stiffness_block_accumulator
// Accumulates the 3x3 linear elasticity stiffness block over the cells of a
// node and emits the nine entries, column-major, with a saturation flag.
// Path of a node's last cell to its result: input register, product stage,
// five fold stages, bound stage, output register. Throughput: one cell per
// cycle unless the output stalls; one result per CELLS_PER_NODE cells.
// Reset: synchronous; clears accumulators, cell count, saturation flag, valids.
// ----------------------------------------------------------------------------
module elasticity_stiffness_block_accumulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  esba_pkg::t_in       i_lambda_modulus,
    input  esba_pkg::t_in       i_shear_modulus,
    input  esba_pkg::t_in       i_int_00,
    input  esba_pkg::t_in       i_int_01,
    input  esba_pkg::t_in       i_int_02,
    input  esba_pkg::t_in       i_int_10,
    input  esba_pkg::t_in       i_int_11,
    input  esba_pkg::t_in       i_int_12,
    input  esba_pkg::t_in       i_int_20,
    input  esba_pkg::t_in       i_int_21,
    input  esba_pkg::t_in       i_int_22,
    input  logic                i_center_node,
    output logic                o_valid,
    input  logic                i_stall,
    output esba_pkg::t_acc      o_m00,
    output esba_pkg::t_acc      o_m10,
    output esba_pkg::t_acc      o_m20,
    output esba_pkg::t_acc      o_m01,
    output esba_pkg::t_acc      o_m11,
    output esba_pkg::t_acc      o_m21,
    output esba_pkg::t_acc      o_m02,
    output esba_pkg::t_acc      o_m12,
    output esba_pkg::t_acc      o_m22,
    output logic                o_saturated
);

    logic [esba_pkg::TOP_STG-1:0] r_vld;
    logic [esba_pkg::TOP_STG-1:0] w_ld;

    esba_pkg::t_in   r_lam;
    esba_pkg::t_in   r_mu;
    esba_pkg::t_in   r_ig [esba_pkg::N_ENT];
    logic            r_ctr0;
    esba_pkg::t_acc  r_pl [esba_pkg::N_ENT];
    esba_pkg::t_acc  r_pm [esba_pkg::N_ENT];
    logic            r_ctr1;

    esba_pkg::t_cnt  r_cnt;
    logic            r_ovf;
    logic            r_out_valid;
    esba_pkg::t_acc  r_m [esba_pkg::N_ENT];
    logic            r_sat;

    logic            w_last;
    logic            w_out_ok;
    logic            w_acc_ok;
    logic            w_acc_mv;
    logic            w_any_sat;

    esba_pkg::t_lane_ctl w_ctl;
    esba_pkg::t_acc      w_term [esba_pkg::N_ENT][esba_pkg::N_TERMS];
    esba_pkg::t_acc      w_acc_next [esba_pkg::N_ENT];
    logic [esba_pkg::N_ENT-1:0] w_sat;

    // stage enables
    assign w_last   = (r_cnt == esba_pkg::CNT_LAST);
    assign w_out_ok = !r_out_valid || !i_stall;
    assign w_acc_ok = !w_last || w_out_ok;
    assign w_acc_mv = r_vld[esba_pkg::TOP_STG-1] && w_acc_ok;

    always_comb begin
        w_ld[esba_pkg::TOP_STG-1] = !r_vld[esba_pkg::TOP_STG-1] || w_acc_ok;
        for (int k = esba_pkg::TOP_STG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign o_stall = !w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < esba_pkg::TOP_STG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_lam    <= i_lambda_modulus;
            r_mu     <= i_shear_modulus;
            r_ig[0]  <= i_int_00;
            r_ig[1]  <= i_int_01;
            r_ig[2]  <= i_int_02;
            r_ig[3]  <= i_int_10;
            r_ig[4]  <= i_int_11;
            r_ig[5]  <= i_int_12;
            r_ig[6]  <= i_int_20;
            r_ig[7]  <= i_int_21;
            r_ig[8]  <= i_int_22;
            r_ctr0   <= i_center_node;
        end
    end

    // products, exact in 64 bits
    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            for (int k = 0; k < esba_pkg::N_ENT; k++) begin
                r_pl[k] <= esba_pkg::t_acc'(r_lam) * esba_pkg::t_acc'(r_ig[k]);
                r_pm[k] <= esba_pkg::t_acc'(r_mu) * esba_pkg::t_acc'(r_ig[k]);
            end
            r_ctr1 <= r_ctr0;
        end
    end

    // term selection per entry, index = col * 3 + row
    for (genvar e = 0; e < esba_pkg::N_ENT; e++) begin : g_ent
        localparam int R = e % 3;
        localparam int C = e / 3;
        if (R == C) begin : g_diag
            localparam int A = (R + 1) % 3;
            localparam int B = (R + 2) % 3;
            assign w_term[e][0] = r_pl[R*4];
            assign w_term[e][1] = r_pm[R*4];
            assign w_term[e][2] = r_pm[R*4];
            assign w_term[e][3] = r_pm[A*4];
            assign w_term[e][4] = r_pm[B*4];
        end else begin : g_off
            assign w_term[e][0] = r_ctr1 ? r_pl[R*3+C] : r_pl[C*3+R];
            assign w_term[e][1] = r_ctr1 ? r_pm[C*3+R] : r_pm[R*3+C];
            for (genvar t = 2; t < esba_pkg::N_TERMS; t++) begin : g_pad
                assign w_term[e][t] = '0;
            end
        end

        esba_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_term     (w_term[e]),
            .o_acc_next (w_acc_next[e]),
            .o_sat      (w_sat[e])
        );
    end

    assign w_ctl.ld      = w_ld[esba_pkg::TOP_STG-1:2];
    assign w_ctl.acc_en  = w_acc_mv;
    assign w_ctl.acc_clr = w_last;
    assign w_any_sat     = |w_sat;

    // cell count and saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_acc_mv) begin
            if (w_last) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= r_cnt + esba_pkg::t_cnt'(1);
                r_ovf <= r_ovf || w_any_sat;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc_mv && w_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_mv && w_last) begin
            r_m   <= w_acc_next;
            r_sat <= r_ovf || w_any_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_m00       = r_m[0];
    assign o_m10       = r_m[1];
    assign o_m20       = r_m[2];
    assign o_m01       = r_m[3];
    assign o_m11       = r_m[4];
    assign o_m21       = r_m[5];
    assign o_m02       = r_m[6];
    assign o_m12       = r_m[7];
    assign o_m22       = r_m[8];
    assign o_saturated = r_sat;

endmodule

@@ hw/rtl/esba_checker.sv @@
// ----------------------------------------------------------------------------
// esba_checker
// Port-level checks for the elasticity stiffness block accumulator.
// ----------------------------------------------------------------------------
module esba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input esba_pkg::t_in  i_lambda_modulus,
    input esba_pkg::t_in  i_shear_modulus,
    input esba_pkg::t_in  i_int_00,
    input esba_pkg::t_in  i_int_01,
    input esba_pkg::t_in  i_int_02,
    input esba_pkg::t_in  i_int_10,
    input esba_pkg::t_in  i_int_11,
    input esba_pkg::t_in  i_int_12,
    input esba_pkg::t_in  i_int_20,
    input esba_pkg::t_in  i_int_21,
    input esba_pkg::t_in  i_int_22,
    input logic           i_center_node,
    input logic           o_valid,
    input logic           i_stall,
    input esba_pkg::t_acc o_m00,
    input esba_pkg::t_acc o_m10,
    input esba_pkg::t_acc o_m20,
    input esba_pkg::t_acc o_m01,
    input esba_pkg::t_acc o_m11,
    input esba_pkg::t_acc o_m21,
    input esba_pkg::t_acc o_m02,
    input esba_pkg::t_acc o_m12,
    input esba_pkg::t_acc o_m22,
    input logic           o_saturated
);

    // input backpressure only when the output is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_no_result_from_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_rst_n))
        else $error("result appeared straight out of reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_m00) && $stable(o_m11) && $stable(o_m22)
            && $stable(o_m10) && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind elasticity_stiffness_block_accumulator esba_checker u_esba_checker (.*);

@@ tb/tb_elasticity_stiffness_block_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elasticity_stiffness_block_accumulator
// Streams cell contributions into the stiffness block accumulator and checks
// every emitted 3x3 block against a cycle-free predictor that accumulates the
// same saturating Q18.46 sums. Directed blocks hit both saturation rails, the
// recovery from a clamped entry and the center node role swap; random traffic
// then runs under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_elasticity_stiffness_block_accumulator;

    localparam int            CYCLE_LIMIT  = 400000;
    localparam int            DRAIN_CYCLES = 20;
    localparam int            RAND_CELLS   = 376;
    localparam esba_pkg::t_in IN_MAX       = 32'sh7fff_ffff;
    localparam esba_pkg::t_in IN_MIN       = 32'sh8000_0000;

    typedef struct {
        esba_pkg::t_in lam;
        esba_pkg::t_in mu;
        esba_pkg::t_in ig[3][3];
        logic          center;
    } t_cell;

    typedef struct {
        esba_pkg::t_acc m[9];
        logic           sat;
    } t_stiffness;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    esba_pkg::t_in i_lambda_modulus;
    esba_pkg::t_in i_shear_modulus;
    esba_pkg::t_in i_int_00, i_int_01, i_int_02;
    esba_pkg::t_in i_int_10, i_int_11, i_int_12;
    esba_pkg::t_in i_int_20, i_int_21, i_int_22;
    logic          i_center_node;
    logic          o_valid;
    logic          i_stall;
    esba_pkg::t_acc o_m00, o_m10, o_m20, o_m01, o_m11, o_m21, o_m02, o_m12, o_m22;
    logic          o_saturated;

    // predictor state
    esba_pkg::t_acc stiffness_acc[9];
    esba_pkg::t_cnt cell_count;
    logic           overflow_seen;
    t_stiffness     stiffness_q[$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int cells_sent;
    int blocks_checked;
    int sat_blocks;
    int cycle_count;

    elasticity_stiffness_block_accumulator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_lambda_modulus (i_lambda_modulus),
        .i_shear_modulus  (i_shear_modulus),
        .i_int_00         (i_int_00),
        .i_int_01         (i_int_01),
        .i_int_02         (i_int_02),
        .i_int_10         (i_int_10),
        .i_int_11         (i_int_11),
        .i_int_12         (i_int_12),
        .i_int_20         (i_int_20),
        .i_int_21         (i_int_21),
        .i_int_22         (i_int_22),
        .i_center_node    (i_center_node),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_m00            (o_m00),
        .o_m10            (o_m10),
        .o_m20            (o_m20),
        .o_m01            (o_m01),
        .o_m11            (o_m11),
        .o_m21            (o_m21),
        .o_m02            (o_m02),
        .o_m12            (o_m12),
        .o_m22            (o_m22),
        .o_saturated      (o_saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d blocks outstanding",
                     cycle_count, stiffness_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void add_sat(int idx, esba_pkg::t_acc term);
        esba_pkg::t_acc sum;
        sum = stiffness_acc[idx] + term;
        if (stiffness_acc[idx][esba_pkg::ACC_W-1] == term[esba_pkg::ACC_W-1]
                && sum[esba_pkg::ACC_W-1] != term[esba_pkg::ACC_W-1]) begin
            stiffness_acc[idx] = term[esba_pkg::ACC_W-1] ? esba_pkg::ACC_MIN
                                                         : esba_pkg::ACC_MAX;
            overflow_seen = 1'b1;
        end else begin
            stiffness_acc[idx] = sum;
        end
    endfunction

    function automatic void accumulate_cell(t_cell cdat);
        esba_pkg::t_acc lam;
        esba_pkg::t_acc mu;
        esba_pkg::t_acc g[3][3];
        int             idx;
        int             a;
        int             b;
        t_stiffness     blk;
        lam = cdat.lam;
        mu  = cdat.mu;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                g[r][k] = cdat.ig[r][k];
            end
        end
        for (int col = 0; col < 3; col++) begin
            for (int row = 0; row < 3; row++) begin
                idx = col * 3 + row;
                if (row == col) begin
                    a = (row + 1) % 3;
                    b = (row + 2) % 3;
                    add_sat(idx, lam * g[row][row]);
                    add_sat(idx, mu * g[row][row]);
                    add_sat(idx, mu * g[row][row]);
                    add_sat(idx, mu * g[a][a]);
                    add_sat(idx, mu * g[b][b]);
                end else if (cdat.center) begin
                    add_sat(idx, lam * g[row][col]);
                    add_sat(idx, mu * g[col][row]);
                end else begin
                    add_sat(idx, lam * g[col][row]);
                    add_sat(idx, mu * g[row][col]);
                end
            end
        end
        if (cell_count == esba_pkg::CNT_LAST) begin
            blk.m   = stiffness_acc;
            blk.sat = overflow_seen;
            stiffness_q.push_back(blk);
            for (int k = 0; k < esba_pkg::N_ENT; k++) begin
                stiffness_acc[k] = '0;
            end
            cell_count    = '0;
            overflow_seen = 1'b0;
        end else begin
            cell_count = cell_count + esba_pkg::t_cnt'(1);
        end
    endfunction

    task automatic send_cell(t_cell cdat);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_lambda_modulus <= cdat.lam;
        i_shear_modulus  <= cdat.mu;
        i_int_00         <= cdat.ig[0][0];
        i_int_01         <= cdat.ig[0][1];
        i_int_02         <= cdat.ig[0][2];
        i_int_10         <= cdat.ig[1][0];
        i_int_11         <= cdat.ig[1][1];
        i_int_12         <= cdat.ig[1][2];
        i_int_20         <= cdat.ig[2][0];
        i_int_21         <= cdat.ig[2][1];
        i_int_22         <= cdat.ig[2][2];
        i_center_node    <= cdat.center;
        i_valid          <= 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        accumulate_cell(cdat);
        cells_sent++;
    endtask

    task automatic check_block();
        t_stiffness     exp_blk;
        esba_pkg::t_acc got[9];
        string          names[9];
        got   = '{o_m00, o_m10, o_m20, o_m01, o_m11, o_m21, o_m02, o_m12, o_m22};
        names = '{"m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"};
        if (stiffness_q.size() == 0) begin
            report_mismatch("result transfer with no block pending");
        end else begin
            exp_blk = stiffness_q.pop_front();
            blocks_checked++;
            if (exp_blk.sat) begin
                sat_blocks++;
            end
            for (int k = 0; k < esba_pkg::N_ENT; k++) begin
                if (got[k] !== exp_blk.m[k]) begin
                    report_mismatch($sformatf("block %0d %s got %h expected %h",
                                    blocks_checked, names[k], got[k], exp_blk.m[k]));
                end
            end
            if (o_saturated !== exp_blk.sat) begin
                report_mismatch($sformatf("block %0d saturated got %b expected %b",
                                blocks_checked, o_saturated, exp_blk.sat));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            check_block();
        end
    end

    function automatic t_cell uniform_cell(esba_pkg::t_in lam, esba_pkg::t_in mu,
                                           esba_pkg::t_in ig, logic center);
        t_cell cdat;
        cdat.lam    = lam;
        cdat.mu     = mu;
        cdat.center = center;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                cdat.ig[r][k] = ig;
            end
        end
        return cdat;
    endfunction

    // 0: full range, 1: small around zero, 2: corner values
    function automatic esba_pkg::t_in rand_word(int mode);
        esba_pkg::t_in w;
        case (mode)
            0: begin
                w = esba_pkg::t_in'($urandom);
            end
            1: begin
                w = esba_pkg::t_in'($urandom_range(8191)) - esba_pkg::t_in'(4096);
            end
            default: begin
                case ($urandom_range(4))
                    0:       w = IN_MIN;
                    1:       w = IN_MAX;
                    2:       w = '0;
                    3:       w = -1;
                    default: w = 1;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic t_cell rand_cell();
        t_cell cdat;
        int    cell_mode;
        cell_mode = $urandom_range(3);
        cdat.lam    = rand_word((cell_mode == 3) ? $urandom_range(2) : cell_mode);
        cdat.mu     = rand_word((cell_mode == 3) ? $urandom_range(2) : cell_mode);
        cdat.center = 1'($urandom_range(1));
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                cdat.ig[r][k] = rand_word((cell_mode == 3) ? $urandom_range(2) : cell_mode);
            end
        end
        return cdat;
    endfunction

    // every product is +2^62, entries run into the positive rail
    task automatic test_positive_saturation();
        for (int n = 0; n < esba_pkg::CELLS_PER_NODE; n++) begin
            send_cell(uniform_cell(IN_MIN, IN_MIN, IN_MIN, 1'b1));
        end
    endtask

    // clamp at the negative rail, then a last cell pulls the entries back up
    task automatic test_negative_saturation();
        for (int n = 0; n < esba_pkg::CELLS_PER_NODE - 1; n++) begin
            send_cell(uniform_cell(IN_MAX, IN_MAX, IN_MIN, 1'b0));
        end
        send_cell(uniform_cell(IN_MAX, IN_MAX, IN_MAX, 1'b0));
    endtask

    // distinct integrals so transposed roles show up; center flag toggles per cell
    task automatic test_center_roles();
        t_cell cdat;
        for (int n = 0; n < esba_pkg::CELLS_PER_NODE; n++) begin
            cdat.lam    = esba_pkg::t_in'((n + 1) << 16);
            cdat.mu     = -esba_pkg::t_in'((2 * n + 3) << 16);
            cdat.center = n[0];
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    cdat.ig[r][k] = esba_pkg::t_in'((r * 3 + k + 1) << 20)
                                    * ((r > k) ? -1 : 1);
                end
            end
            send_cell(cdat);
        end
    endtask

    task automatic test_random_traffic(int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < RAND_CELLS; n++) begin
            send_cell(rand_cell());
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_stall          <= 1'b0;
        i_lambda_modulus <= '0;
        i_shear_modulus  <= '0;
        i_int_00         <= '0;
        i_int_01         <= '0;
        i_int_02         <= '0;
        i_int_10         <= '0;
        i_int_11         <= '0;
        i_int_12         <= '0;
        i_int_20         <= '0;
        i_int_21         <= '0;
        i_int_22         <= '0;
        i_center_node    <= 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        error_count      = 0;
        cells_sent       = 0;
        blocks_checked   = 0;
        sat_blocks       = 0;
        cycle_count      = 0;
        cell_count       = '0;
        overflow_seen    = 1'b0;
        for (int k = 0; k < esba_pkg::N_ENT; k++) begin
            stiffness_acc[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_positive_saturation();
        test_negative_saturation();
        test_center_roles();
        test_random_traffic(0, 0);
        test_random_traffic(48, 0);
        test_random_traffic(0, 48);
        test_random_traffic(27, 27);
        i_valid <= 1'b0;

        while (stiffness_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d cells, checked %0d stiffness blocks (%0d saturated)",
                 cells_sent, blocks_checked, sat_blocks);
        $display("idle/stall mixes: none, sender 48%%, receiver 48%%, both 27%%");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
